>>> sv/rvd_pkg.sv
// shared constants for the radial vignette darkening pipeline
package rvd_pkg;

   localparam int MAX_SIDE   = 4096;
   localparam int COLOR_BITS = 16;

   // field widths fixed by the interface
   localparam int POS_W  = 12;
   localparam int SIZE_W = 13;
   localparam int REG_W  = 16;
   localparam int IDX_W  = 3;

   // widths derived from the largest image side
   localparam int DIV_W = $clog2(MAX_SIDE);

   // Q1.16 fixed point
   localparam int      Q_W     = 17;
   localparam logic [Q_W-1:0] ONE_Q16 = 17'h10000;

   // register indexes
   localparam logic [IDX_W-1:0] REG_STRENGTH = 3'd0;
   localparam logic [IDX_W-1:0] REG_RADIUS   = 3'd1;
   localparam logic [IDX_W-1:0] REG_FALLOFF  = 3'd2;
   localparam logic [IDX_W-1:0] REG_CENTER_H = 3'd3;
   localparam logic [IDX_W-1:0] REG_CENTER_V = 3'd4;
   localparam logic [IDX_W-1:0] REG_WIDTH    = 3'd5;
   localparam logic [IDX_W-1:0] REG_HEIGHT   = 3'd6;

   // register reset values
   localparam logic [REG_W-1:0]  RST_STRENGTH = 16'd11469;
   localparam logic [REG_W-1:0]  RST_RADIUS   = 16'd32768;
   localparam logic [REG_W-1:0]  RST_FALLOFF  = 16'd22938;
   localparam logic [REG_W-1:0]  RST_CENTER_H = 16'd32768;
   localparam logic [REG_W-1:0]  RST_CENTER_V = 16'd32768;
   localparam logic [SIZE_W-1:0] RST_WIDTH    = 13'd1920;
   localparam logic [SIZE_W-1:0] RST_HEIGHT   = 13'd1080;

endpackage

>>> sv/radial_vignette_darken.sv
// top level: radial vignette darkening of a pixel stream
//
//   channel | direction | handshake           | payload
//   req     | in        | req_tvalid/tready   | column, row, red_in, green_in, blue_in
//   rsp     | out       | rsp_tvalid/tready   | red_out, green_out, blue_out
//   csr     | in        | csr_valid/ready     | csr_index, csr_data
//
// one pixel per clock when nothing stalls; 58 register stages from req to
// rsp_tvalid: the 17-stage coordinate divider, the 16-stage square root and
// the 16-stage ramp divider plus eight arithmetic stages and the output register.
// the whole pipeline advances when the output register is empty or taken, so
// a stall holds every transaction in place. synchronous reset clears the valid
// bits and loads the register defaults; csr writes are always taken.
module radial_vignette_darken
   import rvd_pkg::*;
#(
   parameter int COLOR_BITS_P = COLOR_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // column, row, red_in, green_in, blue_in, zero pad
   input  logic [((2*POS_W+3*COLOR_BITS_P+7)/8)*8-1:0] req_tdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // red_out, green_out, blue_out, zero pad
   output logic [((3*COLOR_BITS_P+7)/8)*8-1:0] rsp_tdata,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [IDX_W-1:0]     csr_index,
   input  logic [REG_W-1:0]     csr_data
);

   localparam int CB     = COLOR_BITS_P;
   localparam int OUT_W  = ((3*CB+7)/8)*8;
   localparam int NUM_W  = POS_W + 17;
   localparam int COL3_W = 3*CB;

   // ---------------- configuration registers
   logic [REG_W-1:0]  strength_ff, radius_ff, falloff_ff, cx_ff, cy_ff;
   logic [SIZE_W-1:0] width_ff, height_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         strength_ff <= RST_STRENGTH;
         radius_ff   <= RST_RADIUS;
         falloff_ff  <= RST_FALLOFF;
         cx_ff       <= RST_CENTER_H;
         cy_ff       <= RST_CENTER_V;
         width_ff    <= RST_WIDTH;
         height_ff   <= RST_HEIGHT;
      end else if (csr_valid) begin
         case (csr_index)
            REG_STRENGTH: strength_ff <= csr_data;
            REG_RADIUS:   radius_ff   <= csr_data;
            REG_FALLOFF:  falloff_ff  <= csr_data;
            REG_CENTER_H: cx_ff       <= csr_data;
            REG_CENTER_V: cy_ff       <= csr_data;
            REG_WIDTH:    width_ff    <= csr_data[SIZE_W-1:0];
            REG_HEIGHT:   height_ff   <= csr_data[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   // static values derived from configuration
   logic [SIZE_W-1:0] side_x, side_y;
   logic              one_x, one_y, bypass;
   logic [DIV_W-1:0]  div_x, div_y;
   logic [Q_W-1:0]    edge0, edge1, span;
   logic [Q_W:0]      edge_sum;

   always_comb begin
      side_x  = (width_ff  > SIZE_W'(MAX_SIDE)) ? SIZE_W'(MAX_SIDE) : width_ff;
      side_y  = (height_ff > SIZE_W'(MAX_SIDE)) ? SIZE_W'(MAX_SIDE) : height_ff;
      one_x   = (side_x < SIZE_W'(2));
      one_y   = (side_y < SIZE_W'(2));
      div_x   = one_x ? DIV_W'(1) : DIV_W'(side_x - SIZE_W'(1));
      div_y   = one_y ? DIV_W'(1) : DIV_W'(side_y - SIZE_W'(1));
      bypass  = (width_ff == '0) || (height_ff == '0);
      edge0   = {1'b0, radius_ff};
      edge_sum = {2'b00, radius_ff} + {2'b00, falloff_ff};
      edge1   = (edge_sum > {1'b0, ONE_Q16}) ? ONE_Q16 : edge_sum[Q_W-1:0];
      // ramp keeps at least one lsb
      if (edge1 < edge0 + Q_W'(1)) begin
         edge1 = edge0 + Q_W'(1);
      end
      span    = edge1 - edge0;
   end

   // ---------------- pipeline advance
   logic rsp_valid_ff;
   logic en;

   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   // ---------------- stage a: coordinate numerators
   logic [POS_W-1:0]  col, row;
   logic [COL3_W-1:0] colors;
   logic [NUM_W-1:0]  num_x, num_y;

   assign col    = req_tdata[POS_W-1:0];
   assign row    = req_tdata[2*POS_W-1:POS_W];
   assign colors = req_tdata[2*POS_W+COL3_W-1:2*POS_W];

   always_comb begin
      num_x = {1'b0, col, 16'h0000} + NUM_W'(div_x >> 1);
      num_y = {1'b0, row, 16'h0000} + NUM_W'(div_y >> 1);
   end

   logic                       a_vld_ff;
   logic [1:0][DIV_W-1:0]      a_rem_ff;
   logic [1:0][Q_W-1:0]        a_lo_ff;
   logic [COL3_W+4:0]          a_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (en) begin
         a_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_rem_ff[0] <= DIV_W'(num_x >> 17);
         a_rem_ff[1] <= DIV_W'(num_y >> 17);
         a_lo_ff[0]  <= num_x[Q_W-1:0];
         a_lo_ff[1]  <= num_y[Q_W-1:0];
         // side: colors, bypass, one_x, sat_x, one_y, sat_y
         a_side_ff   <= {colors, bypass, one_x, (DIV_W'(col) > div_x),
                         one_y, (DIV_W'(row) > div_y)};
      end
   end

   // ---------------- coordinate divider
   logic                  n_vld;
   logic [1:0][Q_W-1:0]   n_quo;
   logic [COL3_W+4:0]     n_side;

   rvd_div_pipe #(
      .QW    (Q_W),
      .DW    (DIV_W),
      .LANES (2),
      .SW    (COL3_W+5)
   ) u_norm_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (a_vld_ff),
      .in_rem    (a_rem_ff),
      .in_lo     (a_lo_ff),
      .in_div    ({div_y, div_x}),
      .in_side   (a_side_ff),
      .out_valid (n_vld),
      .out_quo   (n_quo),
      .out_side  (n_side)
   );

   // ---------------- stage b: offsets from the center
   logic [Q_W-1:0] nx, ny, offs_x, offs_y;

   always_comb begin
      if (n_side[3]) begin
         nx = '0;
      end else if (n_side[2]) begin
         nx = ONE_Q16;
      end else begin
         nx = n_quo[0];
      end
      if (n_side[1]) begin
         ny = '0;
      end else if (n_side[0]) begin
         ny = ONE_Q16;
      end else begin
         ny = n_quo[1];
      end
      offs_x = (nx >= {1'b0, cx_ff}) ? nx - {1'b0, cx_ff} : {1'b0, cx_ff} - nx;
      offs_y = (ny >= {1'b0, cy_ff}) ? ny - {1'b0, cy_ff} : {1'b0, cy_ff} - ny;
   end

   logic              b_vld_ff;
   logic [Q_W-1:0]    b_dx_ff, b_dy_ff;
   logic [COL3_W:0]   b_side_ff;

   // ---------------- stage c: squares
   logic              c_vld_ff;
   logic [2*Q_W-1:0]  c_sqx_ff, c_sqy_ff;
   logic [COL3_W:0]   c_side_ff;

   // ---------------- stage d: radicand and cap
   logic [2*Q_W:0]    sq_sum;
   logic [2*Q_W+1:0]  radicand;
   logic              d_vld_ff;
   logic [31:0]       d_val_ff;
   logic [COL3_W+1:0] d_side_ff;

   assign sq_sum   = {1'b0, c_sqx_ff} + {1'b0, c_sqy_ff};
   assign radicand = {sq_sum, 1'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
      end else if (en) begin
         b_vld_ff <= n_vld;
         c_vld_ff <= b_vld_ff;
         d_vld_ff <= c_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_dx_ff   <= offs_x;
         b_dy_ff   <= offs_y;
         b_side_ff <= n_side[COL3_W+4:4];
         c_sqx_ff  <= (2*Q_W)'(b_dx_ff) * (2*Q_W)'(b_dx_ff);
         c_sqy_ff  <= (2*Q_W)'(b_dy_ff) * (2*Q_W)'(b_dy_ff);
         c_side_ff <= b_side_ff;
         d_val_ff  <= radicand[31:0];
         // a radicand of 2^32 or more gives a distance capped at one
         d_side_ff <= {c_side_ff, (radicand[2*Q_W+1:32] != '0)};
      end
   end

   // ---------------- square root
   logic              s_vld;
   logic [15:0]       s_root;
   logic [COL3_W+1:0] s_side;

   rvd_sqrt_pipe #(
      .SW (COL3_W+2)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (d_vld_ff),
      .in_value  (d_val_ff),
      .in_side   (d_side_ff),
      .out_valid (s_vld),
      .out_root  (s_root),
      .out_side  (s_side)
   );

   // ---------------- stage e: position on the ramp
   logic [Q_W-1:0] rad_dist, ramp_pos;
   logic           inside_r, ramp_sat;

   always_comb begin
      rad_dist = s_side[0] ? ONE_Q16 : {1'b0, s_root};
      inside_r = (rad_dist <= edge0);
      ramp_pos = inside_r ? '0 : rad_dist - edge0;
      ramp_sat = (ramp_pos >= span);
   end

   logic              e_vld_ff;
   logic [Q_W-1:0]    e_rem_ff;
   logic [COL3_W+2:0] e_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_vld_ff <= 1'b0;
      end else if (en) begin
         e_vld_ff <= s_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_rem_ff  <= ramp_sat ? '0 : ramp_pos;
         e_side_ff <= {s_side[COL3_W+1:1], inside_r, ramp_sat};
      end
   end

   // ---------------- ramp divider
   logic                  t_vld;
   logic [0:0][15:0]      t_quo;
   logic [COL3_W+2:0]     t_side;

   rvd_div_pipe #(
      .QW    (16),
      .DW    (Q_W),
      .LANES (1),
      .SW    (COL3_W+3)
   ) u_ramp_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (e_vld_ff),
      .in_rem    (e_rem_ff),
      .in_lo     (16'h0000),
      .in_div    (span),
      .in_side   (e_side_ff),
      .out_valid (t_vld),
      .out_quo   (t_quo),
      .out_side  (t_side)
   );

   // ---------------- stage f: strength times ramp
   logic [Q_W-1:0] t_val;

   always_comb begin
      if (t_side[1]) begin
         t_val = '0;
      end else if (t_side[0]) begin
         t_val = ONE_Q16;
      end else begin
         t_val = {1'b0, t_quo[0]};
      end
   end

   logic                  f_vld_ff;
   logic [REG_W+Q_W-1:0]  f_st_ff;
   logic [COL3_W:0]       f_side_ff;

   // ---------------- stage g: darkening factor
   logic [REG_W+Q_W:0]    st_round;
   logic [REG_W+Q_W-15:0] st_val;
   logic [Q_W-1:0]        darken;

   always_comb begin
      st_round = {1'b0, f_st_ff} + (REG_W+Q_W+1)'(16384);
      st_val   = st_round[REG_W+Q_W:15];
      darken   = (st_val >= (REG_W+Q_W-14)'(ONE_Q16)) ? '0
               : ONE_Q16 - Q_W'(st_val);
   end

   logic              g_vld_ff;
   logic [Q_W-1:0]    g_dark_ff;
   logic [COL3_W:0]   g_side_ff;

   // ---------------- stage h: channel products
   logic                     h_vld_ff;
   logic [2:0][CB+Q_W-1:0]   h_prod_ff;
   logic [COL3_W:0]          h_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff <= 1'b0;
         g_vld_ff <= 1'b0;
         h_vld_ff <= 1'b0;
      end else if (en) begin
         f_vld_ff <= t_vld;
         g_vld_ff <= f_vld_ff;
         h_vld_ff <= g_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f_st_ff   <= (REG_W+Q_W)'(strength_ff) * (REG_W+Q_W)'(t_val);
         f_side_ff <= t_side[COL3_W+2:2];
         g_dark_ff <= darken;
         g_side_ff <= f_side_ff;
         for (int i = 0; i < 3; i++) begin
            h_prod_ff[i] <= (CB+Q_W)'(g_side_ff[1+i*CB +: CB]) * (CB+Q_W)'(g_dark_ff);
         end
         h_side_ff <= g_side_ff;
      end
   end

   // ---------------- output register
   logic [COL3_W-1:0] shaded;

   always_comb begin
      logic [CB+Q_W:0] rnd;
      for (int i = 0; i < 3; i++) begin
         rnd = {1'b0, h_prod_ff[i]} + (CB+Q_W+1)'(32768);
         // zero image size passes the pixel through
         shaded[i*CB +: CB] = h_side_ff[0] ? h_side_ff[1+i*CB +: CB] : rnd[CB+15:16];
      end
   end

   logic [COL3_W-1:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= h_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= shaded;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = OUT_W'(rsp_data_ff);

endmodule

>>> sv/rvd_div_pipe.sv
// pipelined restoring divider, one quotient bit per stage, one or more lanes
module rvd_div_pipe
   import rvd_pkg::*;
#(
   parameter int QW    = 17,
   parameter int DW    = 12,
   parameter int LANES = 2,
   parameter int SW    = 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic [LANES-1:0][DW-1:0]     in_rem,
   input  logic [LANES-1:0][QW-1:0]     in_lo,
   input  logic [LANES-1:0][DW-1:0]     in_div,
   input  logic [SW-1:0]                in_side,
   output logic                         out_valid,
   output logic [LANES-1:0][QW-1:0]     out_quo,
   output logic [SW-1:0]                out_side
);

   logic [LANES-1:0][DW-1:0] rem_w  [QW+1];
   logic [LANES-1:0][QW-1:0] lo_w   [QW+1];
   logic [SW-1:0]            side_w [QW+1];
   logic                     vld_w  [QW+1];

   assign rem_w[0]  = in_rem;
   assign lo_w[0]   = in_lo;
   assign side_w[0] = in_side;
   assign vld_w[0]  = in_valid;

   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic [LANES-1:0][DW-1:0] rem_in;
      logic [LANES-1:0][QW-1:0] lo_in;
      logic [LANES-1:0][DW-1:0] rem_ff;
      logic [LANES-1:0][QW-1:0] lo_ff;
      logic [SW-1:0]            side_ff;
      logic                     vld_ff;

      // numerator bits leave at the top, quotient bits enter at the bottom
      always_comb begin
         logic [DW:0] tmp;
         logic [DW:0] diff;
         logic        ge;
         for (int l = 0; l < LANES; l++) begin
            tmp  = {rem_w[k][l], lo_w[k][l][QW-1]};
            diff = tmp - {1'b0, in_div[l]};
            ge   = (tmp >= {1'b0, in_div[l]});
            rem_in[l] = ge ? diff[DW-1:0] : tmp[DW-1:0];
            lo_in[l]  = {lo_w[k][l][QW-2:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else if (en) begin
            vld_ff <= vld_w[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff  <= rem_in;
            lo_ff   <= lo_in;
            side_ff <= side_w[k];
         end
      end

      assign rem_w[k+1]  = rem_ff;
      assign lo_w[k+1]   = lo_ff;
      assign side_w[k+1] = side_ff;
      assign vld_w[k+1]  = vld_ff;
   end

   assign out_valid = vld_w[QW];
   assign out_quo   = lo_w[QW];
   assign out_side  = side_w[QW];

endmodule

>>> sv/rvd_sqrt_pipe.sv
// pipelined integer square root of a 32-bit value, one root bit per stage
module rvd_sqrt_pipe
   import rvd_pkg::*;
#(
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [31:0]   in_value,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [15:0]   out_root,
   output logic [SW-1:0] out_side
);

   localparam int STAGES = 16;

   logic [17:0]   rem_w  [STAGES+1];
   logic [15:0]   root_w [STAGES+1];
   logic [31:0]   val_w  [STAGES+1];
   logic [SW-1:0] side_w [STAGES+1];
   logic          vld_w  [STAGES+1];

   assign rem_w[0]  = '0;
   assign root_w[0] = '0;
   assign val_w[0]  = in_value;
   assign side_w[0] = in_side;
   assign vld_w[0]  = in_valid;

   for (genvar k = 0; k < STAGES; k++) begin : g_stage
      logic [17:0]   rem_in;
      logic [15:0]   root_in;
      logic [17:0]   rem_ff;
      logic [15:0]   root_ff;
      logic [31:0]   val_ff;
      logic [SW-1:0] side_ff;
      logic          vld_ff;

      always_comb begin
         logic [19:0] tmp;
         logic [19:0] trial;
         logic [19:0] diff;
         logic        ge;
         tmp     = {rem_w[k], val_w[k][31:30]};
         trial   = {2'b00, root_w[k], 2'b01};
         diff    = tmp - trial;
         ge      = (tmp >= trial);
         rem_in  = ge ? diff[17:0] : tmp[17:0];
         root_in = {root_w[k][14:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else if (en) begin
            vld_ff <= vld_w[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff  <= rem_in;
            root_ff <= root_in;
            val_ff  <= {val_w[k][29:0], 2'b00};
            side_ff <= side_w[k];
         end
      end

      assign rem_w[k+1]  = rem_ff;
      assign root_w[k+1] = root_ff;
      assign val_w[k+1]  = val_ff;
      assign side_w[k+1] = side_ff;
      assign vld_w[k+1]  = vld_ff;
   end

   assign out_valid = vld_w[STAGES];
   assign out_root  = root_w[STAGES];
   assign out_side  = side_w[STAGES];

endmodule
